// ----- sv/assert_macros.svh -----
// assertion helpers for the decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define U8D_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define U8D_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define U8D_ASSERT(lbl, clk, rst, prop)
`define U8D_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- sv/u8d_pkg.sv -----
package u8d_pkg;

  localparam int CP_W = 21;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_SKIP    = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [1:0]        trails_left;
    logic [1:0]        trail_total;
    logic [CP_W-1:0]   accumulated_code;
  } dec_state_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            valid_res;
    logic            run_last;
  } result_t;

  typedef struct packed {
    dec_state_t state;
    result_t    res0;
    result_t    res1;
    logic [1:0] nres;
  } dec_out_t;

  function automatic logic [1:0] lead_trails(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= 8'hC0 && b <= 8'hDF) n = 2'd1;
    else if (b >= 8'hE0 && b <= 8'hEF) n = 2'd2;
    else if (b >= 8'hF0 && b <= 8'hF4) n = 2'd3;
    return n;
  endfunction

  function automatic logic [7:0] lead_mask(input logic [1:0] n);
    logic [7:0] m;
    case (n)
      2'd1:    m = 8'h1F;
      2'd2:    m = 8'h0F;
      2'd3:    m = 8'h07;
      default: m = 8'h7F;
    endcase
    return m;
  endfunction

  function automatic logic [CP_W-1:0] min_value(input logic [1:0] n);
    logic [CP_W-1:0] v;
    case (n)
      2'd1:    v = 21'h000080;
      2'd2:    v = 21'h000800;
      2'd3:    v = 21'h010000;
      default: v = 21'h000000;
    endcase
    return v;
  endfunction

  function automatic logic is_char(input logic [CP_W-1:0] c, input logic rej);
    logic ok;
    ok = 1'b1;
    if (c > 21'h10FFFF) ok = 1'b0;
    if (c >= 21'h00D800 && c <= 21'h00DFFF) ok = 1'b0;
    if (rej) begin
      if (c >= 21'h00FDD0 && c <= 21'h00FDEF) ok = 1'b0;
      if (c[15:1] == 15'h7FFF) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ----- sv/u8d_in_if.sv -----
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ----- sv/u8d_out_if.sv -----
interface u8d_out_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CP_W-1:0]  code_point;
  logic                      valid_res;
  logic                      run_last;

  modport source (output valid, output code_point, output valid_res, output run_last,
                  input ready);
  modport sink (input valid, input code_point, input valid_res, input run_last,
                output ready);
endinterface

// ----- sv/u8d_decode.sv -----
module u8d_decode (
  input  u8d_pkg::dec_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                end_of_string,
  input  logic                reject_nonchars,
  output u8d_pkg::dec_out_t   dec
);

  u8d_pkg::dec_state_t          bg_state;
  u8d_pkg::result_t             bg_res;
  logic                         bg_emit;
  logic [1:0]                   lt;
  logic [u8d_pkg::CP_W-1:0]     acc_n;
  logic [1:0]                   tl_n;
  logic                         is_tr;
  logic                         ok;

  assign lt    = u8d_pkg::lead_trails(data_byte);
  assign acc_n = {st.accumulated_code[u8d_pkg::CP_W-7:0], data_byte[5:0]};
  assign tl_n  = st.trails_left - 2'd1;
  assign is_tr = (data_byte[7:6] == 2'b10);
  assign ok    = u8d_pkg::is_char(acc_n, reject_nonchars);

  // start of a new sequence
  always_comb begin
    bg_state = st;
    bg_res   = '0;
    bg_emit  = 1'b0;
    if (!data_byte[7]) begin
      bg_state.phase     = u8d_pkg::PH_IDLE;
      bg_emit            = 1'b1;
      bg_res.code_point  = {13'd0, data_byte};
      bg_res.valid_res   = 1'b1;
    end else if (lt == 2'd0) begin
      bg_state.phase = end_of_string ? u8d_pkg::PH_IDLE : u8d_pkg::PH_SKIP;
      bg_emit        = end_of_string;
    end else begin
      bg_state.trail_total      = lt;
      bg_state.trails_left      = lt;
      bg_state.accumulated_code = {13'd0, data_byte & u8d_pkg::lead_mask(lt)};
      bg_state.phase            = end_of_string ? u8d_pkg::PH_IDLE : u8d_pkg::PH_COLLECT;
      bg_emit                   = end_of_string;
    end
  end

  always_comb begin
    dec.state = st;
    dec.res0  = '0;
    dec.res1  = '0;
    dec.nres  = 2'd0;
    unique case (st.phase)
      u8d_pkg::PH_COLLECT: begin
        if (is_tr) begin
          dec.state.accumulated_code = acc_n;
          dec.state.trails_left      = tl_n;
          if (tl_n == 2'd0) begin
            if (acc_n < u8d_pkg::min_value(st.trail_total)) begin
              // overlong: swallow following trail bytes
              dec.state.phase = end_of_string ? u8d_pkg::PH_IDLE : u8d_pkg::PH_SKIP;
              dec.nres        = {1'b0, end_of_string};
            end else begin
              dec.state.phase      = u8d_pkg::PH_IDLE;
              dec.nres             = 2'd1;
              dec.res0.valid_res   = ok;
              dec.res0.code_point  = ok ? acc_n : '0;
            end
          end else if (end_of_string) begin
            dec.state.phase = u8d_pkg::PH_IDLE;
            dec.nres        = 2'd1;
          end
        end else begin
          dec.state = bg_state;
          dec.res1  = bg_res;
          dec.nres  = 2'd1 + {1'b0, bg_emit};
        end
      end
      u8d_pkg::PH_SKIP: begin
        if (is_tr) begin
          if (end_of_string) begin
            dec.state.phase = u8d_pkg::PH_IDLE;
            dec.nres        = 2'd1;
          end
        end else begin
          dec.state = bg_state;
          dec.res1  = bg_res;
          dec.nres  = 2'd1 + {1'b0, bg_emit};
        end
      end
      default: begin
        dec.state = bg_state;
        dec.res0  = bg_res;
        dec.nres  = {1'b0, bg_emit};
      end
    endcase
    if (dec.nres == 2'd1) dec.res0.run_last = 1'b1;
    if (dec.nres == 2'd2) dec.res1.run_last = 1'b1;
  end

endmodule

// ----- sv/u8d_result_queue.sv -----
`include "assert_macros.svh"

module u8d_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  u8d_pkg::result_t res0,
  input  u8d_pkg::result_t res1,
  output logic [1:0]       count,
  u8d_out_if.source        out_ch
);

  u8d_pkg::result_t q [2];
  u8d_pkg::result_t q_next [2];
  logic [1:0]       count_next;
  logic [1:0]       base;
  logic             pop;

  assign pop  = out_ch.valid && out_ch.ready;
  assign base = count - {1'b0, pop};

  always_comb begin
    q_next[0] = pop ? q[1] : q[0];
    q_next[1] = q[1];
    if (push_n != 2'd0) begin
      case (base)
        2'd0: begin
          q_next[0] = res0;
          if (push_n == 2'd2) q_next[1] = res1;
        end
        default: q_next[1] = res0;
      endcase
    end
    count_next = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  assign out_ch.valid      = (count != 2'd0);
  assign out_ch.code_point = q[0].code_point;
  assign out_ch.valid_res  = q[0].valid_res;
  assign out_ch.run_last   = q[0].run_last;

  `U8D_NEVER(a_no_overflow, clk, rst, ({1'b0, base} + {1'b0, push_n}) > 3'd2)
  `U8D_ASSERT(a_hold_idle, clk, rst, (push_n == 2'd0 && !pop) |=> $stable(count))
  `U8D_ASSERT(a_count_step, clk, rst, (push_n == 2'd1 && pop) |=> $stable(count))
  `U8D_NEVER(a_bad_payload, clk, rst, out_ch.valid && !out_ch.valid_res && out_ch.code_point != '0)

endmodule

// ----- sv/utf8_stream_decoder_top.sv -----
// the input stage registers each accepted byte; the decoder works on that register and its
//   results are written into the result queue, from which they are offered on out_ch
// throughput: one byte per cycle while each byte gives at most one result and out_ch is ready;
//   a byte with two results waits for an empty queue, as it admits only entries free before the clock edge
// reset: rst (synchronous) returns the decoder to idle, empties the input and
//   result stages and clears reject_nonchars
module utf8_stream_decoder_top (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  logic                reject_nonchars;
  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_eos;
  u8d_pkg::dec_state_t st;
  u8d_pkg::dec_out_t   dec;
  logic [1:0]          q_count;
  logic                fire;
  logic                in_take;

  u8d_decode u_decode (
    .st              (st),
    .data_byte       (in_byte),
    .end_of_string   (in_eos),
    .reject_nonchars (reject_nonchars),
    .dec             (dec)
  );

  assign fire        = in_valid && (({1'b0, q_count} + {1'b0, dec.nres}) <= 3'd2);
  assign in_ch.ready = !in_valid || fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_nonchars <= 1'b0;
      in_valid        <= 1'b0;
      st              <= '{phase: u8d_pkg::PH_IDLE, trails_left: 2'd0, trail_total: 2'd0,
                           accumulated_code: '0};
    end else begin
      if (cfg_wr_en) reject_nonchars <= cfg_wr_data;
      in_valid <= in_take || (in_valid && !fire);
      if (fire) st <= dec.state;
    end
    if (in_take) begin
      in_byte <= in_ch.data_byte;
      in_eos  <= in_ch.end_of_string;
    end
  end

  u8d_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_n (fire ? dec.nres : 2'd0),
    .res0   (dec.res0),
    .res1   (dec.res1),
    .count  (q_count),
    .out_ch (out_ch)
  );

endmodule
